/* sv/mmcn_pkg.sv */
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared types and constants of the min-max column normalizer.
// ----------------------------------------------------------------------------
package mmcn_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int NORM_W   = 17;
    localparam int CFG_W    = 5;

    // default sizes of the sample store and the column tables
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int MAX_COLS_DEF    = 16;

    // reset value of the column count register
    localparam logic [CFG_W-1:0] NUM_COLS_RST = 5'd1;

    // quotient bit counter
    localparam int QBIT_W = $clog2(NORM_W);

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SUB,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* sv/mmcn_item_if.sv */
// ----------------------------------------------------------------------------
// mmcn_item_if
// Input channel: a load or emit command with its sample.
// ----------------------------------------------------------------------------
interface mmcn_item_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [mmcn_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output command, output sample_value, input ready);
    modport sink   (input valid, input command, input sample_value, output ready);

endinterface

/* sv/mmcn_result_if.sv */
// ----------------------------------------------------------------------------
// mmcn_result_if
// Output channel: one normalized entry and its last flag.
// ----------------------------------------------------------------------------
interface mmcn_result_if;

    logic                          valid;
    logic                          ready;
    logic [mmcn_pkg::NORM_W-1:0]   norm_value;
    logic                          last_entry;

    modport source (output valid, output norm_value, output last_entry, input ready);
    modport sink   (input valid, input norm_value, input last_entry, output ready);

endinterface

/* sv/minmax_column_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// minmax_column_normalizer_unit
// Load words (command 0) fill the sample store in row-major order, num_cols
// columns per row, and update each column's minimum and maximum; a load is
// dropped once the store is full or emission has begun. Emit
// words (command 1) return the stored entries in load order as
// (value - column min) / (column max - column min) in unsigned Q1.16,
// truncated, or 0 for a column whose max equals its min. The final entry
// carries last_entry and the block starts empty for a new data set. An emit
// word holds off the input through one store read, one clamp, one subtract,
// 17 steps of a restoring divider that shifts in one quotient bit per cycle,
// and one output load. The result register lets the next word in while a
// result waits. After a change of num_cols the column counter is brought
// into range by one subtraction per cycle before a word is taken.
// ----------------------------------------------------------------------------
module minmax_column_normalizer_unit #(
    parameter int MAX_ENTRIES = mmcn_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_COLS    = mmcn_pkg::MAX_COLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mmcn_pkg::CFG_W-1:0]  cfg_wr_data,
    mmcn_item_if.sink                   items,
    mmcn_result_if.source               results
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CFW   = $clog2(MAX_COLS + 1);
    localparam int SW    = mmcn_pkg::SAMPLE_W;
    localparam int QW    = mmcn_pkg::NORM_W;
    localparam int BW    = mmcn_pkg::QBIT_W;

    // storage
    logic [SW-1:0]        store_mem [MAX_ENTRIES];
    logic signed [SW-1:0] min_reg [MAX_COLS];
    logic signed [SW-1:0] max_reg [MAX_COLS];
    logic [MAX_COLS-1:0]  col_valid_reg;

    // control
    mmcn_pkg::state_t     state_reg, state_next;
    logic [mmcn_pkg::CFG_W-1:0] num_cols_reg;
    logic [CNT_W-1:0]     ec_reg;
    logic [CNT_W-1:0]     rp_reg;
    logic [CW-1:0]        col_reg;
    logic [BW-1:0]        bit_cnt_reg;

    // datapath
    logic signed [SW-1:0] rd_data_reg;
    logic signed [SW-1:0] lo_reg, hi_reg, v_reg;
    logic [SW-1:0]        span_reg;
    logic [SW:0]          rem_reg;
    logic [QW-1:0]        quo_reg;
    logic                 zero_reg;
    logic                 last_reg;

    // output register
    logic                 out_valid_reg;
    logic [QW-1:0]        out_norm_reg;
    logic                 out_last_reg;

    logic [CFW-1:0]       cols_eff;
    logic                 col_over;
    logic                 in_ready;
    logic                 accept;
    logic                 is_emit;
    logic                 load_go;
    logic                 emit_go;
    logic                 last_now;
    logic [CW-1:0]        rd_col;
    logic [CW-1:0]        col_inc;
    logic signed [SW-1:0] s_in;
    logic                 out_load;
    logic                 ge;
    logic [SW:0]          r_after;

    // effective column count: 0 acts as 1, clipped to the table size
    always_comb
    begin
        priority if (num_cols_reg == '0)
            cols_eff = CFW'(1);
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
            cols_eff = CFW'(MAX_COLS);
        else
            cols_eff = CFW'(num_cols_reg);
    end

    assign col_over = CFW'(col_reg) >= cols_eff;
    assign s_in     = items.sample_value;
    assign is_emit  = (items.command == mmcn_pkg::CMD_EMIT);
    assign accept   = items.valid && in_ready;
    assign load_go  = accept && !is_emit && (rp_reg == '0) && (ec_reg < CNT_W'(MAX_ENTRIES));
    assign emit_go  = accept && is_emit && (ec_reg != '0);
    assign last_now = (rp_reg + CNT_W'(1)) >= ec_reg;
    assign rd_col   = (is_emit && (rp_reg == '0)) ? '0 : col_reg;
    assign col_inc  = ((CFW'(rd_col) + CFW'(1)) == cols_eff) ? '0 : CW'(rd_col + CW'(1));

    assign items.ready = in_ready;

    // divider step
    assign ge      = rem_reg >= {1'b0, span_reg};
    assign r_after = ge ? (rem_reg - {1'b0, span_reg}) : rem_reg;

    // ------------------------------------------------------------------ fsm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mmcn_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            mmcn_pkg::ST_IDLE:
            begin
                in_ready = !col_over;
                if (emit_go)
                    state_next = mmcn_pkg::ST_FETCH;
            end
            mmcn_pkg::ST_FETCH:
                state_next = mmcn_pkg::ST_SUB;
            mmcn_pkg::ST_SUB:
                state_next = mmcn_pkg::ST_DIV;
            mmcn_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == BW'(QW - 1))
                    state_next = mmcn_pkg::ST_DONE;
            end
            mmcn_pkg::ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = mmcn_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mmcn_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg  <= mmcn_pkg::NUM_COLS_RST;
            ec_reg        <= '0;
            rp_reg        <= '0;
            col_reg       <= '0;
            col_valid_reg <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                num_cols_reg <= cfg_wr_data;

            if ((state_reg == mmcn_pkg::ST_IDLE) && col_over)
                col_reg <= CW'(CFW'(col_reg) - cols_eff);
            else if (load_go)
            begin
                col_valid_reg[rd_col] <= 1'b1;
                ec_reg                <= ec_reg + CNT_W'(1);
                col_reg               <= col_inc;
            end
            else if (emit_go)
            begin
                if (last_now)
                begin
                    // data set complete, start over empty
                    ec_reg        <= '0;
                    rp_reg        <= '0;
                    col_reg       <= '0;
                    col_valid_reg <= '0;
                end
                else
                begin
                    rp_reg  <= rp_reg + CNT_W'(1);
                    col_reg <= col_inc;
                end
            end

            if (state_reg == mmcn_pkg::ST_SUB)
                bit_cnt_reg <= '0;
            else if (state_reg == mmcn_pkg::ST_DIV)
                bit_cnt_reg <= bit_cnt_reg + BW'(1);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // --------------------------------------------------------- sample store
    always_ff @(posedge clk)
    begin
        if (load_go)
            store_mem[ec_reg[AW-1:0]] <= items.sample_value;
        if (emit_go)
            rd_data_reg <= store_mem[rp_reg[AW-1:0]];
    end

    // column min / max, first load of a column sets both
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            if (!col_valid_reg[rd_col])
            begin
                min_reg[rd_col] <= s_in;
                max_reg[rd_col] <= s_in;
            end
            else
            begin
                if (s_in < min_reg[rd_col])
                    min_reg[rd_col] <= s_in;
                if (s_in > max_reg[rd_col])
                    max_reg[rd_col] <= s_in;
            end
        end
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            lo_reg   <= min_reg[rd_col];
            hi_reg   <= max_reg[rd_col];
            zero_reg <= !col_valid_reg[rd_col] || (min_reg[rd_col] == max_reg[rd_col]);
            last_reg <= last_now;
        end

        if (state_reg == mmcn_pkg::ST_FETCH)
        begin
            priority if (rd_data_reg < lo_reg)
                v_reg <= lo_reg;
            else if (rd_data_reg > hi_reg)
                v_reg <= hi_reg;
            else
                v_reg <= rd_data_reg;
            span_reg <= SW'(hi_reg - lo_reg);
        end

        if (state_reg == mmcn_pkg::ST_SUB)
        begin
            rem_reg <= {1'b0, SW'(v_reg - lo_reg)};
            quo_reg <= '0;
        end
        else if (state_reg == mmcn_pkg::ST_DIV)
        begin
            // remainder after each subtraction stays below the span, so the shift never overflows
            rem_reg <= {r_after[SW-1:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end

        if (out_load)
        begin
            out_norm_reg <= zero_reg ? '0 : quo_reg;
            out_last_reg <= last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.norm_value = out_norm_reg;
    assign results.last_entry = out_last_reg;

    // ----------------------------------------------------------- assertions
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg == '0) || (rp_reg < ec_reg))
        else $error("read pointer past entry count");

    a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (state_reg == mmcn_pkg::ST_FETCH))
        else $error("emit word did not start the datapath");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mmcn_pkg::ST_DIV) && (bit_cnt_reg == BW'(QW - 1)))
        |=> (state_reg == mmcn_pkg::ST_DONE))
        else $error("divider ran past its last quotient bit");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> results.valid)
        else $error("finished result not presented");

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.norm_value <= (QW'(1) << (QW - 1))))
        else $error("normalized value above one");

endmodule
